### rtl/bsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared widths, register indexes and class codes for the breakpoint span
// classifier and its checker.
// ----------------------------------------------------------------------------
package bsc_pkg;

   // field widths
   localparam int NODE_W  = 20;
   localparam int LEN_W   = 12;
   localparam int SPAN_W  = 16;
   localparam int SUM_W   = 16;
   localparam int COUNT_W = 32;
   localparam int CLASS_W = 2;
   localparam int INDEX_W = 2;

   // stream word widths
   localparam int REQ_DATA_W = NODE_W + LEN_W;
   localparam int RSP_DATA_W = 2 * COUNT_W;

   // configuration register indexes
   localparam logic [INDEX_W-1:0] CSR_FIRST_VARIANT = 2'd0;
   localparam logic [INDEX_W-1:0] CSR_LAST_VARIANT  = 2'd1;
   localparam logic [INDEX_W-1:0] CSR_MIN_SPAN      = 2'd2;

   // reset value of the minimum span
   localparam logic [SPAN_W-1:0] MIN_SPAN_RESET = 16'd10;

   // flank class codes
   localparam logic [CLASS_W-1:0] CLASS_NONE  = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_LEFT  = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_RIGHT = 2'd2;
   localparam logic [CLASS_W-1:0] CLASS_BOTH  = 2'd3;

   // saturation limits
   localparam logic [SUM_W-1:0]   SUM_MAX   = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

### rtl/breakpoint_span_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breakpoint_span_classifier
// Sorts the node segments of read alignments into left flank, variant and
// right flank sums and classes each finished read by the breakpoints it spans.
// ----------------------------------------------------------------------------
// Usage
//   req channel: one word per node segment, tdata = {span_length, node_id},
//   tlast set on the last segment of an alignment.
//   rsp channel: one word per request word, tdata = {right_count, left_count},
//   tuser = flank class (zero while the alignment is open), tlast set when
//   that request word closed an alignment.
//   csr channel: index 0 first variant node, 1 last variant node, 2 minimum
//   span; other indexes are dropped. Always ready; write only while idle.
// Pipeline and throughput
//   A word is captured in the input register, then classified, summed and
//   counted into the output register, which drives rsp_tvalid; while rsp
//   stalls with the output full, the word waits in the input register. One
//   word per cycle sustained while rsp_tready stays high; the loop that sets
//   it is the flank sum and counter update.
// Reset and stall
//   Reset empties both registers, clears the sums and counters and loads the
//   register reset values. When rsp stalls the output word holds, the input
//   register still fills, and req_tready drops only with both registers full.
// ----------------------------------------------------------------------------
module breakpoint_span_classifier (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bsc_pkg::REQ_DATA_W-1:0]      req_tdata,   // node_id, span_length
   input  logic                                req_tlast,
   // result stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bsc_pkg::RSP_DATA_W-1:0]      rsp_tdata,   // left_count, right_count
   output logic [bsc_pkg::CLASS_W-1:0]         rsp_tuser,   // flank_class
   output logic                                rsp_tlast,
   // configuration writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bsc_pkg::INDEX_W-1:0]         csr_index,
   input  logic [bsc_pkg::NODE_W-1:0]          csr_data
);
   import bsc_pkg::*;

   // configuration registers
   logic [NODE_W-1:0]  first_ff, last_ff;
   logic [SPAN_W-1:0]  min_span_ff;

   // input register
   logic               in_valid_ff;
   logic [NODE_W-1:0]  node_ff;
   logic [LEN_W-1:0]   len_ff;
   logic               last_node_ff;

   // accumulation state
   logic [SUM_W-1:0]   left_sum_ff, var_sum_ff, right_sum_ff;
   logic [SUM_W-1:0]   left_sum_in, var_sum_in, right_sum_in;
   logic [COUNT_W-1:0] left_reads_ff, right_reads_ff;
   logic [COUNT_W-1:0] left_reads_in, right_reads_in;

   // output register
   logic               out_valid_ff;
   logic               out_done_ff;
   logic [CLASS_W-1:0] out_class_ff;
   logic [CLASS_W-1:0] class_in;

   // working values
   logic               advance;
   logic               to_left, to_var;
   logic [SUM_W-1:0]   sel_sum;
   logic [SUM_W:0]     raw_sum;
   logic [SUM_W-1:0]   sat_sum;
   logic [SUM_W-1:0]   left_new, var_new, right_new;
   logic [SUM_W:0]     var_right, var_left;
   logic               sup_left, sup_right;

   // handshakes
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   // configuration write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff    <= '0;
         last_ff     <= '0;
         min_span_ff <= MIN_SPAN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FIRST_VARIANT: first_ff    <= csr_data;
            CSR_LAST_VARIANT:  last_ff     <= csr_data;
            CSR_MIN_SPAN:      min_span_ff <= csr_data[SPAN_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         node_ff      <= req_tdata[NODE_W-1:0];
         len_ff       <= req_tdata[REQ_DATA_W-1:NODE_W];
         last_node_ff <= req_tlast;
      end
   end

   // flank select and saturating add
   always_comb begin
      to_left = node_ff < first_ff;
      to_var  = !to_left && (node_ff <= last_ff);
      if (to_left) begin
         sel_sum = left_sum_ff;
      end else if (to_var) begin
         sel_sum = var_sum_ff;
      end else begin
         sel_sum = right_sum_ff;
      end
      raw_sum = {1'b0, sel_sum} + {{(SUM_W + 1 - LEN_W){1'b0}}, len_ff};
      sat_sum = raw_sum[SUM_W] ? SUM_MAX : raw_sum[SUM_W-1:0];
      left_new  = to_left ? sat_sum : left_sum_ff;
      var_new   = to_var ? sat_sum : var_sum_ff;
      right_new = (!to_left && !to_var) ? sat_sum : right_sum_ff;
   end

   // breakpoint span checks and counters
   always_comb begin
      var_right = {1'b0, var_new} + {1'b0, right_new};
      var_left  = {1'b0, var_new} + {1'b0, left_new};
      sup_left  = (left_new >= min_span_ff) && (var_right >= {1'b0, min_span_ff});
      sup_right = (var_left >= {1'b0, min_span_ff}) && (right_new >= min_span_ff);
      class_in       = CLASS_NONE;
      left_reads_in  = left_reads_ff;
      right_reads_in = right_reads_ff;
      left_sum_in    = left_new;
      var_sum_in     = var_new;
      right_sum_in   = right_new;
      if (last_node_ff) begin
         if (sup_left) begin
            class_in = class_in | CLASS_LEFT;
            if (left_reads_ff != COUNT_MAX) begin
               left_reads_in = left_reads_ff + COUNT_W'(1);
            end
         end
         if (sup_right) begin
            class_in = class_in | CLASS_RIGHT;
            if (right_reads_ff != COUNT_MAX) begin
               right_reads_in = right_reads_ff + COUNT_W'(1);
            end
         end
         left_sum_in  = '0;
         var_sum_in   = '0;
         right_sum_in = '0;
      end
   end

   // state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         left_sum_ff    <= '0;
         var_sum_ff     <= '0;
         right_sum_ff   <= '0;
         left_reads_ff  <= '0;
         right_reads_ff <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (advance) begin
            left_sum_ff    <= left_sum_in;
            var_sum_ff     <= var_sum_in;
            right_sum_ff   <= right_sum_in;
            left_reads_ff  <= left_reads_in;
            right_reads_ff <= right_reads_in;
            out_valid_ff   <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff   <= 1'b0;
         end
      end
      if (advance) begin
         out_done_ff  <= last_node_ff;
         out_class_ff <= class_in;
      end
   end

   // result word
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {right_reads_ff, left_reads_ff};
   assign rsp_tuser  = out_class_ff;
   assign rsp_tlast  = out_done_ff;

endmodule

### rtl/bsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_checker
// Port-level checks for the breakpoint span classifier, bound to the top level.
// ----------------------------------------------------------------------------
module bsc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [bsc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input logic [bsc_pkg::CLASS_W-1:0]         rsp_tuser,
   input logic                                rsp_tlast
);
   import bsc_pkg::*;

   // no result word right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result word valid right after reset");

   // open alignment carries no class
   a_open_no_class: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == CLASS_NONE)
      else $error("class reported on an open alignment");

   // a left-supporting read implies a nonzero left count
   a_left_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[COUNT_W-1:0] != '0)
      else $error("left support with zero left count");

   // a right-supporting read implies a nonzero right count
   a_right_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata[RSP_DATA_W-1:COUNT_W] != '0)
      else $error("right support with zero right count");

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result word changed");

endmodule

bind breakpoint_span_classifier bsc_checker u_bsc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

### sim/tb_breakpoint_span_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_breakpoint_span_classifier
// Self-checking bench for the breakpoint span classifier. Node segments are
// streamed in as whole read alignments. A local copy of the flank sums and read
// counters predicts every result word, and a monitor compares each accepted
// result word field by field. Directed cases cover the reset settings, each
// flank class, a reversed variant range, register masking and sum saturation.
// Random phases then sweep the settings, and a final test stalls the result side
// long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_breakpoint_span_classifier;
   import bsc_pkg::*;

   localparam logic [NODE_W-1:0]  NODE_MAX    = '1;
   localparam logic [LEN_W-1:0]   LEN_MAX     = '1;
   localparam logic [INDEX_W-1:0] CSR_UNUSED  = 2'd3;
   localparam int                 HOLD_CYCLES = 60;
   localparam int                 PHASES      = 10;

   typedef struct packed {
      logic               done;
      logic [CLASS_W-1:0] flank;
      logic [COUNT_W-1:0] left_cnt;
      logic [COUNT_W-1:0] right_cnt;
   } span_result_type;

   // dut inputs, known from time zero
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // node_id, span_length
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tready = 1'b0;
   logic                  csr_valid  = 1'b0;
   logic [INDEX_W-1:0]    csr_index  = '0;
   logic [NODE_W-1:0]     csr_data   = '0;

   // dut outputs
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // left_count, right_count
   logic [CLASS_W-1:0]    rsp_tuser;   // flank_class
   logic                  rsp_tlast;
   logic                  csr_ready;

   // predictor state
   logic [NODE_W-1:0]  cfg_first   = '0;
   logic [NODE_W-1:0]  cfg_last    = '0;
   logic [SPAN_W-1:0]  cfg_min     = MIN_SPAN_RESET;
   logic [SUM_W-1:0]   left_sum    = '0;
   logic [SUM_W-1:0]   variant_sum = '0;
   logic [SUM_W-1:0]   right_sum   = '0;
   logic [COUNT_W-1:0] left_reads  = '0;
   logic [COUNT_W-1:0] right_reads = '0;

   span_result_type pending_results[$];

   // run control and tallies
   bit idle_off     = 1'b0;
   bit hold_request = 1'b0;
   int hold_left    = 0;
   int fail_count   = 0;
   int segments_sent    = 0;
   int alignments_sent  = 0;
   int results_checked  = 0;
   int input_stalls     = 0;
   int class_seen[4]    = '{0, 0, 0, 0};

   breakpoint_span_classifier u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc,
                                                logic [LEN_W-1:0] len);
      logic [SUM_W:0] wide;
      wide = {1'b0, acc} + {{(SUM_W + 1 - LEN_W){1'b0}}, len};
      return wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
   endfunction

   function automatic span_result_type classify_segment(logic [NODE_W-1:0] node,
                                                        logic [LEN_W-1:0]  len,
                                                        logic              last);
      span_result_type res;
      logic [SUM_W:0]  var_right;
      logic [SUM_W:0]  var_left;
      res = '0;
      // range compares in order, so a reversed range never hits the variant
      if (node < cfg_first)
         left_sum = sat_sum(left_sum, len);
      else if (node <= cfg_last)
         variant_sum = sat_sum(variant_sum, len);
      else
         right_sum = sat_sum(right_sum, len);
      if (last) begin
         // side sums compared at full width, no wrap
         var_right = {1'b0, variant_sum} + {1'b0, right_sum};
         var_left  = {1'b0, variant_sum} + {1'b0, left_sum};
         res.flank = CLASS_NONE;
         if (left_sum >= cfg_min && var_right >= {1'b0, cfg_min}) begin
            res.flank = res.flank | CLASS_LEFT;
            if (left_reads != COUNT_MAX) left_reads = left_reads + COUNT_W'(1);
         end
         if (var_left >= {1'b0, cfg_min} && right_sum >= cfg_min) begin
            res.flank = res.flank | CLASS_RIGHT;
            if (right_reads != COUNT_MAX) right_reads = right_reads + COUNT_W'(1);
         end
         left_sum    = '0;
         variant_sum = '0;
         right_sum   = '0;
      end
      res.done      = last;
      res.left_cnt  = left_reads;
      res.right_cnt = right_reads;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // result side: ready with random holds, plus a long forced hold on request
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_rsp_ready
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= idle_off || ($urandom_range(99) >= 8);
      end
   end

   // ------------------------------------------------------------------------
   // result monitor
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      span_result_type want;
      if (!reset) begin
         if (req_tvalid && !req_tready) input_stalls++;
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $error("result word with nothing expected");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               results_checked++;
               if (want.done) class_seen[want.flank]++;
               if (rsp_tlast !== want.done) begin
                  $error("alignment_done: expected %0d, got %0d", want.done, rsp_tlast);
                  fail_count++;
               end
               if (rsp_tuser !== want.flank) begin
                  $error("flank_class: expected %0d, got %0d", want.flank, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tdata[COUNT_W-1:0] !== want.left_cnt) begin
                  $error("left_count: expected %0d, got %0d",
                         want.left_cnt, rsp_tdata[COUNT_W-1:0]);
                  fail_count++;
               end
               if (rsp_tdata[RSP_DATA_W-1:COUNT_W] !== want.right_cnt) begin
                  $error("right_count: expected %0d, got %0d",
                         want.right_cnt, rsp_tdata[RSP_DATA_W-1:COUNT_W]);
                  fail_count++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   task automatic send_segment(input logic [NODE_W-1:0] node,
                               input logic [LEN_W-1:0]  len,
                               input logic              last);
      span_result_type predicted;
      // random gaps before the word
      while (!idle_off && $urandom_range(99) < 8) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {len, node};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted       = classify_segment(node, len, last);
      pending_results = {pending_results, predicted};
      segments_sent++;
      if (last) alignments_sent++;
   endtask

   task automatic write_csr(input logic [INDEX_W-1:0] idx, input logic [NODE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_FIRST_VARIANT: cfg_first = value;
         CSR_LAST_VARIANT:  cfg_last  = value;
         CSR_MIN_SPAN:      cfg_min   = value[SPAN_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // drop valid, let every expected word come back, then idle before returning
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // random picks
   // ------------------------------------------------------------------------
   function automatic logic [NODE_W-1:0] pick_node();
      int unsigned lo;
      int unsigned hi;
      lo = (cfg_first < cfg_last) ? cfg_first : cfg_last;
      hi = (cfg_first < cfg_last) ? cfg_last : cfg_first;
      case ($urandom_range(9))
         0: return NODE_W'($urandom);
         1: return NODE_W'(cfg_first - 1);
         2: return cfg_first;
         3: return cfg_last;
         4: return NODE_W'(cfg_last + 1);
         5: return (lo == 0) ? '0 : NODE_W'($urandom_range(lo - 1, 0));
         6: return NODE_W'($urandom_range(hi, lo));
         7: return (hi == NODE_MAX) ? NODE_W'(hi) : NODE_W'($urandom_range(NODE_MAX, hi + 1));
         8: return '0;
         default: return '1;
      endcase
   endfunction

   function automatic logic [LEN_W-1:0] pick_span();
      int unsigned near;
      near = (cfg_min > LEN_MAX) ? LEN_MAX : cfg_min;
      case ($urandom_range(5))
         0: return '0;
         1: return LEN_MAX;
         2, 3: return LEN_W'($urandom_range(31));
         4: return LEN_W'($urandom_range(near));
         default: return LEN_W'($urandom);
      endcase
   endfunction

   function automatic logic [SPAN_W-1:0] pick_min();
      case ($urandom_range(4))
         0: return '0;
         1: return '1;
         2: return SPAN_W'($urandom_range(64, 1));
         3: return SPAN_W'($urandom_range(8000));
         default: return SPAN_W'($urandom);
      endcase
   endfunction

   // heavy alignments pile max-length words on one node to saturate a sum
   task automatic send_alignment(input int nodes, input bit heavy);
      logic [NODE_W-1:0] bulk_node;
      bulk_node = pick_node();
      for (int k = 0; k < nodes; k++) begin
         if (heavy && k < nodes - 3)
            send_segment(bulk_node, LEN_MAX, 1'b0);
         else
            send_segment(pick_node(), pick_span(), k == nodes - 1);
      end
   endtask

   task automatic configure_phase(input int phase);
      logic [NODE_W-1:0] first_id;
      logic [NODE_W-1:0] last_id;
      logic [NODE_W-1:0] min_word;
      min_word = NODE_W'($urandom);
      case (phase)
         0: begin
            first_id = '0;
            last_id  = NODE_MAX;
            min_word[SPAN_W-1:0] = '0;
         end
         1: begin
            first_id = NODE_MAX;
            last_id  = '0;
            min_word[SPAN_W-1:0] = '1;
         end
         default: begin
            case ($urandom_range(3))
               0: begin
                  first_id = NODE_W'($urandom);
                  last_id  = NODE_W'($urandom);
               end
               1: begin
                  first_id = NODE_W'($urandom_range(NODE_MAX - 64));
                  last_id  = NODE_W'(first_id + $urandom_range(64));
               end
               2: begin
                  first_id = NODE_W'($urandom);
                  last_id  = first_id;
               end
               default: begin
                  // reversed range
                  last_id  = NODE_W'($urandom_range(NODE_MAX - 1));
                  first_id = NODE_W'($urandom_range(NODE_MAX, last_id + 1));
               end
            endcase
            min_word[SPAN_W-1:0] = pick_min();
         end
      endcase
      write_csr(CSR_FIRST_VARIANT, first_id);
      write_csr(CSR_LAST_VARIANT, last_id);
      write_csr(CSR_MIN_SPAN, min_word);
      if ($urandom_range(3) == 0) write_csr(CSR_UNUSED, NODE_W'($urandom));
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // reset settings: node 0 is the whole variant, min span 10
   task automatic test_reset_settings();
      send_segment(20'd0, 12'd10, 1'b0);
      send_segment(20'd1, 12'd10, 1'b1);
      wait_idle();
   endtask

   // none, left and both classes, field extremes, and a write to the unused index
   task automatic test_flank_classes();
      write_csr(CSR_FIRST_VARIANT, 20'd100);
      write_csr(CSR_LAST_VARIANT, 20'd200);
      write_csr(CSR_MIN_SPAN, 20'd10);
      write_csr(CSR_UNUSED, '1);
      send_segment(20'd0, 12'd0, 1'b1);
      send_segment(20'd50, 12'd10, 1'b0);
      send_segment(20'd150, 12'd0, 1'b0);
      send_segment(NODE_MAX, 12'd10, 1'b1);
      send_segment(20'd99, LEN_MAX, 1'b0);
      send_segment(20'd100, 12'd10, 1'b1);
      wait_idle();
   endtask

   // first above last: ids between them go left, variant sum stays zero
   task automatic test_reversed_range();
      write_csr(CSR_FIRST_VARIANT, 20'd500);
      write_csr(CSR_LAST_VARIANT, 20'd100);
      write_csr(CSR_MIN_SPAN, 20'd50);
      send_segment(20'd300, 12'd40, 1'b0);
      send_segment(20'd150, 12'd40, 1'b0);
      send_segment(20'd600, 12'd30, 1'b1);
      wait_idle();
   endtask

   // left sum saturates; variant plus left must not wrap in the right check
   task automatic test_sum_saturation();
      write_csr(CSR_FIRST_VARIANT, 20'd100);
      write_csr(CSR_LAST_VARIANT, 20'd200);
      write_csr(CSR_MIN_SPAN, 20'hF0014);   // upper bits dropped, span 20
      for (int k = 0; k < 17; k++) send_segment(20'd0, LEN_MAX, 1'b0);
      send_segment(20'd150, 12'd10, 1'b0);
      send_segment(20'd300, 12'd20, 1'b1);
      wait_idle();
   endtask

   // sweep of settings with mostly short alignments, some saturating ones
   task automatic test_random_phases();
      int phase_words;
      int nodes;
      bit heavy;
      for (int phase = 0; phase < PHASES; phase++) begin
         configure_phase(phase);
         idle_off    = (phase == 4);
         phase_words = 0;
         while (phase_words < 65) begin
            heavy = ($urandom_range(19) == 0);
            nodes = heavy ? $urandom_range(24, 20) : $urandom_range(6, 1);
            send_alignment(nodes, heavy);
            phase_words += nodes;
         end
         wait_idle();
      end
      idle_off = 1'b0;
   endtask

   // result side held off while words keep coming, so the input stalls
   task automatic test_output_stall();
      write_csr(CSR_FIRST_VARIANT, 20'd1000);
      write_csr(CSR_LAST_VARIANT, 20'd2000);
      write_csr(CSR_MIN_SPAN, 20'd40);
      hold_request = 1'b1;
      for (int k = 0; k < 8; k++) send_alignment(5, 1'b0);
      wait_idle();
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_reset_settings();
      test_flank_classes();
      test_reversed_range();
      test_sum_saturation();
      test_random_phases();
      test_output_stall();
      repeat (10) @(posedge clock);
      $display("sent %0d segments in %0d alignments, checked %0d result words",
               segments_sent, alignments_sent, results_checked);
      $display("classes none/left/right/both %0d/%0d/%0d/%0d, %0d input stall cycles",
               class_seen[CLASS_NONE], class_seen[CLASS_LEFT],
               class_seen[CLASS_RIGHT], class_seen[CLASS_BOTH], input_stalls);
      if (fail_count == 0)
         $display("breakpoint_span_classifier verification clean");
      else
         $display("breakpoint_span_classifier verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #200000;
      $display("breakpoint_span_classifier verification failed");
      $finish;
   end

endmodule
